// ===== hw/rtl/kwrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwrm_pkg
// Shared widths, register indexes, filter coefficients and helper functions
// of the K-weighted RMS meter.
// ----------------------------------------------------------------------------
package kwrm_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int CNT_W        = 4;
  localparam int SAMPLE_W     = 24;
  localparam int SIG_W        = 28;
  localparam int OP_W         = 32;
  localparam int ACC_W        = 64;
  localparam int SQ_W         = 55;
  localparam int SUM_W        = 96;
  localparam int FRAME_W      = 32;
  localparam int RMS_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTING_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd1;

  // Q3.28 coefficients; feedback terms are stored negated so every term adds
  localparam logic signed [OP_W-1:0] S1_B0     = 32'sd412081942;
  localparam logic signed [OP_W-1:0] S1_B1     = -32'sd722546694;
  localparam logic signed [OP_W-1:0] S1_B2     = 32'sd321691121;
  localparam logic signed [OP_W-1:0] S1_NEG_A1 = 32'sd453832898;
  localparam logic signed [OP_W-1:0] S1_NEG_A2 = -32'sd196623811;
  localparam logic signed [OP_W-1:0] S2_B0     = 32'sd268435456;
  localparam logic signed [OP_W-1:0] S2_B1     = -32'sd536870912;
  localparam logic signed [OP_W-1:0] S2_B2     = 32'sd268435456;
  localparam logic signed [OP_W-1:0] S2_NEG_A1 = 32'sd534199296;
  localparam logic signed [OP_W-1:0] S2_NEG_A2 = -32'sd265770496;

  localparam logic signed [ACC_W-1:0] SIG_MAX = 64'sd134217727;
  localparam logic signed [ACC_W-1:0] SIG_MIN = -64'sd134217728;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd134217728;

  // round half up, drop 28 fraction bits, saturate to the signal range
  function automatic logic signed [SIG_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    t = (acc + ROUND_HALF) >>> 28;
    if (t > SIG_MAX) begin
      t = SIG_MAX;
    end else if (t < SIG_MIN) begin
      t = SIG_MIN;
    end
    return t[SIG_W-1:0];
  endfunction

  // zero counts as one, anything above the channel limit is clamped
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] cc);
    logic [CNT_W-1:0] c;
    c = cc;
    if (c == '0) begin
      c = CNT_W'(1);
    end else if (c > CNT_W'(MAX_CHANNELS)) begin
      c = CNT_W'(MAX_CHANNELS);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kwrm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwrm channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface kwrm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [kwrm_pkg::SAMPLE_W-1:0] sample;
  logic                                last_of_block;
  modport source (output valid, sample, last_of_block, input ready);
  modport sink (input valid, sample, last_of_block, output ready);
endinterface

interface kwrm_result_if;
  logic                           valid;
  logic                           ready;
  logic [kwrm_pkg::CH_W-1:0]      channel;
  logic [kwrm_pkg::RMS_W-1:0]     rms_value;
  logic                           last_result;
  modport source (output valid, channel, rms_value, last_result, input ready);
  modport sink (input valid, channel, rms_value, last_result, output ready);
endinterface

interface kwrm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [kwrm_pkg::CFG_IDX_W-1:0]    index;
  logic [kwrm_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/kwrm_rms_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kwrm_rms_unit
// Bit-serial restoring divide of a sum of squares by the frame count, then a
// two-bits-per-step integer square root of mean/4. Saturates to all ones.
// ----------------------------------------------------------------------------
module kwrm_rms_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [kwrm_pkg::SUM_W-1:0]   sum,
  input  wire logic [kwrm_pkg::FRAME_W-1:0] frames,
  output logic                              done,
  output logic [kwrm_pkg::RMS_W-1:0]        rms
);
  import kwrm_pkg::*;

  localparam int ROOT_W = 48;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {IDLE, DIVIDE, ROOT} state_t;

  state_t                 state;
  logic [SUM_W-1:0]       dividend;
  logic [SUM_W-1:0]       quot;
  logic [FRAME_W-1:0]     rem;
  logic [FRAME_W-1:0]     divisor;
  logic [DIV_CNT_W-1:0]   bit_cnt;
  logic [ROOT_W-1:0]      rad;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_W-1:0]      root_bit;

  logic [FRAME_W:0]       trial;
  logic [ROOT_W-1:0]      root_trial;
  logic [SUM_W-1:0]       quot_next;

  assign trial      = {rem, dividend[SUM_W-1]};
  assign root_trial = root + root_bit;
  assign quot_next  = {quot[SUM_W-2:0], trial >= {1'b0, divisor}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            dividend <= sum;
            divisor  <= frames;
            quot     <= '0;
            rem      <= '0;
            bit_cnt  <= DIV_CNT_W'(SUM_W - 1);
            if (frames == '0) begin
              rms  <= '0;
              done <= 1'b1;
            end else begin
              state <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          dividend <= {dividend[SUM_W-2:0], 1'b0};
          quot     <= quot_next;
          // remainder stays below the divisor, so it fits the frame width
          rem      <= (trial >= {1'b0, divisor}) ? FRAME_W'(trial - {1'b0, divisor})
                                                 : FRAME_W'(trial);
          if (bit_cnt == '0) begin
            if (quot_next[SUM_W-1:50] != '0) begin
              rms   <= '1;
              done  <= 1'b1;
              state <= IDLE;
            end else begin
              rad      <= quot_next[49:2];
              root     <= '0;
              root_bit <= ROOT_W'(1) << 46;
              state    <= ROOT;
            end
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        ROOT: begin
          if (rad >= root_trial) begin
            rad  <= rad - root_trial;
            root <= (root >> 1) + root_bit;
          end else begin
            root <= root >> 1;
          end
          root_bit <= root_bit >> 2;
          if (root_bit[0]) begin
            rms   <= (rad >= root_trial) ? RMS_W'((root >> 1) + root_bit)
                                         : RMS_W'(root >> 1);
            done  <= 1'b1;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/k_weighted_rms_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// k_weighted_rms_meter_top
// Interleaved-sample RMS meter with optional two-biquad loudness weighting.
// ----------------------------------------------------------------------------
// A sample is taken in the idle state; both biquads and the square then run as
// eleven multiply-accumulate terms on a single 32x32 multiplier, each term a
// multiply state and then an accumulate state, and an update state writes the
// per-channel state. The block takes no sample until it is back in idle. On the
// sample marked last of block each channel result takes a 96-step divide by the
// frame count and a 24-step square root and is held until taken; after the final
// channel the filter histories, sums and frame count clear and the next block
// starts. Configuration writes are accepted every cycle.
module k_weighted_rms_meter_top (
  input  wire logic    clk,
  input  wire logic    rst,
  kwrm_sample_if.sink  samples,
  kwrm_result_if.source results,
  kwrm_cfg_if.sink     cfg
);
  import kwrm_pkg::*;

  localparam int TERM_W = 4;
  localparam logic [TERM_W-1:0] TERM_S1_LAST = 4'd4;
  localparam logic [TERM_W-1:0] TERM_S2_LAST = 4'd9;
  localparam logic [TERM_W-1:0] TERM_SQUARE  = 4'd10;

  typedef enum logic [2:0] {IDLE, MUL, ACC, UPDATE, RMS_START, RMS_WAIT, SEND} state_t;

  state_t state;

  logic                   weighting_mode;
  logic [CNT_W-1:0]       channel_count;

  logic signed [SIG_W-1:0] x1 [MAX_CHANNELS];
  logic signed [SIG_W-1:0] x2 [MAX_CHANNELS];
  logic signed [SIG_W-1:0] y1 [MAX_CHANNELS];
  logic signed [SIG_W-1:0] y2 [MAX_CHANNELS];
  logic signed [SIG_W-1:0] z1 [MAX_CHANNELS];
  logic signed [SIG_W-1:0] z2 [MAX_CHANNELS];
  logic [SUM_W-1:0]        sums [MAX_CHANNELS];
  logic [FRAME_W-1:0]      frames;
  logic [CH_W-1:0]         pos;

  logic [CNT_W-1:0]        cnt;
  logic [CH_W-1:0]         ch;
  logic                    last;
  logic signed [SIG_W-1:0] x_r;
  logic signed [SIG_W-1:0] y_r;
  logic signed [SIG_W-1:0] z_r;
  logic [TERM_W-1:0]       term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod;
  logic [CH_W-1:0]         out_ch;

  logic signed [OP_W-1:0]  opa;
  logic signed [OP_W-1:0]  opb;
  logic signed [SIG_W-1:0] v;
  logic signed [ACC_W-1:0] acc_next;
  logic [CNT_W-1:0]        cnt_in;
  logic [CNT_W-1:0]        ch_inc;
  logic                    rms_start;
  logic                    rms_done;
  logic [RMS_W-1:0]        rms;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == IDLE);
  assign cnt_in        = clamp_count(channel_count);
  assign v             = weighting_mode ? z_r : x_r;
  assign acc_next      = acc + prod;
  assign ch_inc        = {1'b0, ch} + 1'b1;
  assign rms_start     = (state == RMS_START);

  always_comb begin
    unique case (term)
      4'd0:    begin opa = S1_B0;     opb = OP_W'(x_r);      end
      4'd1:    begin opa = S1_B1;     opb = OP_W'(x1[ch]);   end
      4'd2:    begin opa = S1_B2;     opb = OP_W'(x2[ch]);   end
      4'd3:    begin opa = S1_NEG_A1; opb = OP_W'(y1[ch]);   end
      4'd4:    begin opa = S1_NEG_A2; opb = OP_W'(y2[ch]);   end
      4'd5:    begin opa = S2_B0;     opb = OP_W'(y_r);      end
      4'd6:    begin opa = S2_B1;     opb = OP_W'(y1[ch]);   end
      4'd7:    begin opa = S2_B2;     opb = OP_W'(y2[ch]);   end
      4'd8:    begin opa = S2_NEG_A1; opb = OP_W'(z1[ch]);   end
      4'd9:    begin opa = S2_NEG_A2; opb = OP_W'(z2[ch]);   end
      4'd10:   begin opa = OP_W'(v);  opb = OP_W'(v);        end
      default: begin opa = '0;        opb = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weighting_mode <= 1'b0;
      channel_count  <= CNT_W'(2);
    end else if (cfg.valid) begin
      if (cfg.index == REG_WEIGHTING_MODE) begin
        weighting_mode <= cfg.data[0];
      end else if (cfg.index == REG_CHANNEL_COUNT) begin
        channel_count <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      results.valid <= 1'b0;
      frames        <= '0;
      pos           <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        x1[i] <= '0; x2[i] <= '0; y1[i] <= '0; y2[i] <= '0;
        z1[i] <= '0; z2[i] <= '0; sums[i] <= '0;
      end
    end else begin
      unique case (state)
        IDLE: begin
          if (samples.valid) begin
            cnt   <= cnt_in;
            ch    <= ({1'b0, pos} >= cnt_in) ? '0 : pos;
            last  <= samples.last_of_block;
            x_r   <= SIG_W'(samples.sample);
            term  <= '0;
            acc   <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= opa * opb;
          state <= ACC;
        end
        ACC: begin
          state <= MUL;
          term  <= term + 1'b1;
          if (term == TERM_S1_LAST) begin
            y_r <= round_sat(acc_next);
            acc <= '0;
          end else if (term == TERM_S2_LAST) begin
            z_r <= round_sat(acc_next);
            acc <= '0;
          end else if (term == TERM_SQUARE) begin
            state <= UPDATE;
          end else begin
            acc <= acc_next;
          end
        end
        UPDATE: begin
          x2[ch]   <= x1[ch];
          x1[ch]   <= x_r;
          y2[ch]   <= y1[ch];
          y1[ch]   <= y_r;
          z2[ch]   <= z1[ch];
          z1[ch]   <= z_r;
          sums[ch] <= sums[ch] + SUM_W'(prod[SQ_W-1:0]);
          if (ch == '0 && frames != '1) begin
            frames <= frames + 1'b1;
          end
          pos <= (ch_inc >= cnt) ? '0 : ch_inc[CH_W-1:0];
          if (last) begin
            out_ch <= '0;
            state  <= RMS_START;
          end else begin
            state <= IDLE;
          end
        end
        RMS_START: state <= RMS_WAIT;
        RMS_WAIT: begin
          if (rms_done) begin
            results.valid       <= 1'b1;
            results.channel     <= out_ch;
            results.rms_value   <= rms;
            results.last_result <= ({1'b0, out_ch} + 1'b1 == cnt);
            state               <= SEND;
          end
        end
        SEND: begin
          if (results.ready) begin
            results.valid <= 1'b0;
            if (results.last_result) begin
              // end of block: restart filters, sums and framing
              frames <= '0;
              pos    <= '0;
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                x1[i] <= '0; x2[i] <= '0; y1[i] <= '0; y2[i] <= '0;
                z1[i] <= '0; z2[i] <= '0; sums[i] <= '0;
              end
              state <= IDLE;
            end else begin
              out_ch <= out_ch + 1'b1;
              state  <= RMS_START;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  kwrm_rms_unit u_rms (
    .clk    (clk),
    .rst    (rst),
    .start  (rms_start),
    .sum    (sums[out_ch]),
    .frames (frames),
    .done   (rms_done),
    .rms    (rms)
  );

  a_valid_only_in_send: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> state == SEND) else $error("result valid outside send");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(samples.ready && results.valid)) else $error("sample taken during results");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_result) |=> (frames == '0 && pos == '0))
    else $error("block state not cleared");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// K-weighted RMS meter testbench
// Sends sample blocks under several channel counts and both weighting modes,
// predicts every per-channel RMS result and checks each result transfer in
// order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import kwrm_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [RMS_W-1:0] rms_value;
    logic             last_result;
  } rms_result_t;

  logic clk;
  logic rst;

  kwrm_sample_if samples();
  kwrm_result_if results();
  kwrm_cfg_if    cfg();

  k_weighted_rms_meter_top dut (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .results(results),
    .cfg(cfg)
  );

  // predictor state
  logic             mode_q;
  logic [CNT_W-1:0] count_q;
  longint           shelf_hist [MAX_CHANNELS][4];
  longint           hp_hist [MAX_CHANNELS][2];
  logic [127:0]     sq_sum [MAX_CHANNELS];
  logic [31:0]      frame_cnt;
  int unsigned      pos;

  rms_result_t pending_rms[$];
  int          errors;
  int          hold_off;
  int          stall_left;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint round_clip(longint acc);
    longint t;
    t = (acc + 64'sd134217728) >>> 28;
    if (t > 64'sd134217727) t = 64'sd134217727;
    if (t < -64'sd134217728) t = -64'sd134217728;
    return t;
  endfunction

  function automatic logic [RMS_W-1:0] block_rms(logic [127:0] s, logic [31:0] n);
    logic [127:0] mean;
    logic [63:0]  v, res, b;
    if (n == 0) return '0;
    mean = s / n;
    if (mean >= (128'd1 << 50)) return 24'hFFFFFF;
    v = mean[63:0] >> 2;
    res = 0;
    b = 64'd1 << 46;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[RMS_W-1:0];
  endfunction

  task automatic clear_meter();
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      for (int k = 0; k < 4; k++) shelf_hist[c][k] = 0;
      hp_hist[c][0] = 0;
      hp_hist[c][1] = 0;
      sq_sum[c] = '0;
    end
    frame_cnt = 0;
    pos = 0;
  endtask

  task automatic predict_sample(logic [SAMPLE_W-1:0] raw, logic last);
    int unsigned cnt, ch;
    longint x, y, z, v;
    rms_result_t r;
    cnt = count_q;
    if (cnt == 0) cnt = 1;
    if (cnt > MAX_CHANNELS) cnt = MAX_CHANNELS;
    if (pos >= cnt) pos = 0;
    ch = pos;
    x = longint'($signed(raw));
    y = round_clip(longint'(S1_B0) * x + longint'(S1_B1) * shelf_hist[ch][0]
                   + longint'(S1_B2) * shelf_hist[ch][1]
                   + longint'(S1_NEG_A1) * shelf_hist[ch][2]
                   + longint'(S1_NEG_A2) * shelf_hist[ch][3]);
    z = round_clip(longint'(S2_B0) * y + longint'(S2_B1) * shelf_hist[ch][2]
                   + longint'(S2_B2) * shelf_hist[ch][3]
                   + longint'(S2_NEG_A1) * hp_hist[ch][0]
                   + longint'(S2_NEG_A2) * hp_hist[ch][1]);
    shelf_hist[ch][1] = shelf_hist[ch][0];
    shelf_hist[ch][0] = x;
    shelf_hist[ch][3] = shelf_hist[ch][2];
    shelf_hist[ch][2] = y;
    hp_hist[ch][1] = hp_hist[ch][0];
    hp_hist[ch][0] = z;
    v = mode_q ? z : x;
    sq_sum[ch] = sq_sum[ch] + 128'(v * v);
    if (ch == 0 && frame_cnt != 32'hFFFFFFFF) frame_cnt++;
    pos = ch + 1;
    if (pos >= cnt) pos = 0;
    if (last) begin
      for (int c = 0; c < cnt; c++) begin
        r.channel = c[CH_W-1:0];
        r.rms_value = block_rms(sq_sum[c], frame_cnt);
        r.last_result = (c + 1 == cnt);
        pending_rms.push_back(r);
      end
      clear_meter();
    end
  endtask

  // result side: random stalls, forced hold-off, in-order compare
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        if (pending_rms.size() == 0) begin
          errors++;
          $display("%0t: unexpected result ch=%0d rms=%0d last=%0b", $time,
                   results.channel, results.rms_value, results.last_result);
        end else begin
          rms_result_t e;
          e = pending_rms.pop_front();
          if (results.channel !== e.channel) begin
            errors++;
            $display("%0t: channel expected %0d actual %0d", $time, e.channel,
                     results.channel);
          end
          if (results.rms_value !== e.rms_value) begin
            errors++;
            $display("%0t: rms_value ch%0d expected %0d actual %0d", $time, e.channel,
                     e.rms_value, results.rms_value);
          end
          if (results.last_result !== e.last_result) begin
            errors++;
            $display("%0t: last_result ch%0d expected %0b actual %0b", $time, e.channel,
                     e.last_result, results.last_result);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        results.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        results.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(15, 60);
        results.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("k_weighted_rms_meter_top verification failed");
      $finish;
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic last);
    int gap;
    samples.sample <= s;
    samples.last_of_block <= last;
    samples.valid <= 1'b1;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    predict_sample(s, last);
    gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (pending_rms.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg.index <= idx;
    cfg.data <= val;
    cfg.valid <= 1'b1;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == REG_WEIGHTING_MODE) mode_q = val[0];
    else if (idx == REG_CHANNEL_COUNT) count_q = val;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return SAMPLE_W'($urandom_range(0, 511)) - 24'd256;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_block(int frames, int chans, int tail);
    int total;
    total = frames * chans + tail;
    for (int i = 0; i < total; i++) send_sample(rand_sample(), i == total - 1);
  endtask

  // reset defaults: plain RMS on two channels, field extremes
  task automatic test_defaults();
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h000000, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
  endtask

  // zero counts as one, above eight clamps to eight
  task automatic test_count_clamp();
    write_reg(REG_CHANNEL_COUNT, 4'd0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b1);
    write_reg(REG_CHANNEL_COUNT, 4'd15);
    for (int i = 0; i < 8; i++) send_sample(i[0] ? 24'h7FFFFF : 24'h800000, i == 7);
  endtask

  // weighting on at full scale, then a block ending mid-frame
  task automatic test_weighting();
    write_reg(REG_WEIGHTING_MODE, 4'hF);
    write_reg(REG_CHANNEL_COUNT, 4'd3);
    for (int i = 0; i < 6; i++) send_sample(i[1] ? 24'h7FFFFF : 24'h800000, 1'b0);
    send_sample(24'h123456, 1'b1);
    write_reg(REG_WEIGHTING_MODE, 4'h0);
  endtask

  // hold results off while eight-channel blocks keep coming
  task automatic test_backpressure();
    write_reg(REG_CHANNEL_COUNT, 4'd8);
    hold_off = 3000;
    send_block(1, 8, 0);
    send_block(1, 8, 0);
    drain_results();
  endtask

  task automatic test_random();
    int sent;
    sent = 0;
    while (sent < 130) begin
      int chans, frames, tail;
      write_reg(REG_WEIGHTING_MODE, CFG_DATA_W'($urandom));
      write_reg(REG_CHANNEL_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
      chans = (count_q == 0) ? 1 : (count_q > 8 ? 8 : count_q);
      frames = $urandom_range(1, 4);
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, chans - 1) : 0;
      send_block(frames, chans, tail);
      sent += frames * chans + tail;
    end
  endtask

  initial begin
    errors = 0;
    hold_off = 0;
    stall_left = 0;
    cycles = 0;
    mode_q = 1'b0;
    count_q = 4'd2;
    clear_meter();
    rst = 1'b1;
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.last_of_block = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_count_clamp();
    test_weighting();
    test_backpressure();
    test_random();
    drain_results();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_rms.size() == 0) begin
      $display("k_weighted_rms_meter_top verification clean");
    end else begin
      $display("k_weighted_rms_meter_top verification failed");
    end
    $finish;
  end
endmodule
